@@ hdl/itsbs_pkg.sv @@
`default_nettype none
package itsbs_pkg;

  localparam int unsigned FIELD_W = 64;
  localparam int unsigned QTY_W   = 16;
  localparam int unsigned PRI_W   = 3;

  typedef enum logic [2:0] {
    REQ_INSERT = 3'd0,
    REQ_REMOVE = 3'd1,
    REQ_LIST   = 3'd2,
    REQ_SORT   = 3'd3,
    REQ_SEARCH = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    SORT_NAME = 2'd0,
    SORT_TYPE = 2'd1,
    SORT_PRI  = 2'd2,
    SORT_NONE = 2'd3
  } sort_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_NOT_NAME  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,      // issue table read
    S_CMP,     // use registered read data
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_SORT_LD,
    S_SORT_CMP,
    S_SORT_PUT,
    S_SORT_END, // place the key at the front of the table
    S_OUT
  } state_t;

  typedef struct packed {
    logic [FIELD_W-1:0] name;
    logic [FIELD_W-1:0] kind;
    logic [QTY_W-1:0]   qty;
    logic [PRI_W-1:0]   pri;
  } rec_t;

  // Compare request from the sequencer to the shared comparator.
  typedef struct packed {
    sort_t              mode;
    rec_t               key;
    rec_t               entry;
  } cmp_req_t;

  typedef struct packed {
    logic eq;   // names equal
    logic lt;   // key goes before entry for the selected mode
  } cmp_rsp_t;

endpackage
`default_nettype wire

@@ hdl/itsbs_cmp.sv @@
`default_nettype none
// Shared comparator used by remove, sort and search.
module itsbs_cmp (
  input  var itsbs_pkg::cmp_req_t req,
  output var itsbs_pkg::cmp_rsp_t rsp
);
  always_comb begin
    rsp.eq = (req.key.name == req.entry.name);
    case (req.mode)
      itsbs_pkg::SORT_NAME: rsp.lt = req.key.name < req.entry.name;
      itsbs_pkg::SORT_TYPE: rsp.lt = req.key.kind < req.entry.kind;
      itsbs_pkg::SORT_PRI:  rsp.lt = req.key.pri > req.entry.pri;
      default:              rsp.lt = 1'b0;
    endcase
  end
endmodule
`default_nettype wire

@@ hdl/itsbs_table.sv @@
`default_nettype none
// Record memory: one write port, one registered read port.
module itsbs_table #(
  parameter int unsigned DEPTH = 16
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  var itsbs_pkg::rec_t     wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output var itsbs_pkg::rec_t     rdata
);
  itsbs_pkg::rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ hdl/item_table_sort_and_binary_search_core.sv @@
`default_nettype none
// Sequence: insert writes in S_RD when there is room; every request ends in S_OUT, which raises
// out_valid; list steps each record through S_RD, S_CMP and S_OUT; remove and search probe each
// entry through S_RD and S_CMP, remove then shifts each later entry via S_SHIFT_RD and S_SHIFT_WR;
// sort: S_SORT_LD per record, S_SORT_CMP and S_SORT_PUT per comparison, S_SORT_END at the front.
// Concurrency: one transaction at a time, over the one-write one-read record memory and the one
// shared comparator. in_ready is high only while the sequencer is idle.
// Reset: rst_n, synchronous active low, clears fill count, sorted flag, compare count, result valid
// and the sequencer. Record memory is not cleared; entries beyond the fill count are never read.
module item_table_sort_and_binary_search_core #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned KEY_CHARS = 8
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire [2:0]  in_req_type,
  input  wire [1:0]  in_sort_by,
  input  wire [63:0] in_name_key,
  input  wire [63:0] in_type_key,
  input  wire [15:0] in_quantity,
  input  wire [2:0]  in_priority_req,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [2:0]  out_status,
  output logic [63:0] out_item_name,
  output logic [63:0] out_item_type,
  output logic [15:0] out_item_quantity,
  output logic [2:0]  out_item_priority,
  output logic [3:0]  out_item_position,
  output logic [4:0]  out_entry_count,
  output logic [7:0]  out_compare_count,
  output logic        out_sorted_by_name,
  output logic        out_last
);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = AW + 2;  // signed index with room for -1 and DEPTH
  localparam logic [63:0] KMASK = (KEY_CHARS >= 8) ? '1 : ((64'd1 << (8 * KEY_CHARS)) - 64'd1);

  itsbs_pkg::state_t state_r, state_nxt;

  // Request latched at acceptance.
  itsbs_pkg::req_t  req_r;
  itsbs_pkg::sort_t mode_r;
  itsbs_pkg::rec_t  key_r;     // input record, or the record being inserted by the sort

  logic [CW-1:0] fill_r;
  logic          flag_r;
  logic [7:0]    ccnt_r;

  // Working indexes. i is the outer index, j the probe index; lo/hi for binary search.
  logic [IW-1:0] i_r, j_r, lo_r, hi_r;

  // Result register.
  logic             ov_r;
  itsbs_pkg::status_t ost_r;
  itsbs_pkg::rec_t  orec_r;
  logic [3:0]       opos_r;
  logic             olast_r;

  // Memory port.
  logic            mwe;
  logic [AW-1:0]   mwaddr, mraddr;
  itsbs_pkg::rec_t mwdata, mrdata;

  itsbs_table #(.DEPTH(DEPTH)) u_table (
    .clk(clk), .we(mwe), .waddr(mwaddr), .wdata(mwdata), .raddr(mraddr), .rdata(mrdata)
  );

  itsbs_pkg::cmp_req_t creq;
  itsbs_pkg::cmp_rsp_t crsp;
  itsbs_cmp u_cmp (.req(creq), .rsp(crsp));

  assign creq.mode  = (req_r == itsbs_pkg::REQ_SORT) ? mode_r : itsbs_pkg::SORT_NAME;
  assign creq.key   = key_r;
  assign creq.entry = mrdata;

  logic [IW-1:0] mid;
  assign mid = IW'((lo_r + hi_r) >> 1);

  logic [IW-1:0] fill_ext;
  assign fill_ext = IW'(fill_r);

  // Sequencer-driven control.
  logic accept;
  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == itsbs_pkg::S_IDLE) && !ov_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      itsbs_pkg::S_IDLE: begin
        if (accept) begin
          case (in_req_type)
            itsbs_pkg::REQ_INSERT, itsbs_pkg::REQ_REMOVE, itsbs_pkg::REQ_LIST,
            itsbs_pkg::REQ_SEARCH: state_nxt = itsbs_pkg::S_RD;
            itsbs_pkg::REQ_SORT:   state_nxt = itsbs_pkg::S_SORT_LD;
            default:               state_nxt = itsbs_pkg::S_IDLE;
          endcase
        end
      end
      itsbs_pkg::S_RD: begin
        case (req_r)
          itsbs_pkg::REQ_INSERT: state_nxt = itsbs_pkg::S_OUT;
          itsbs_pkg::REQ_REMOVE, itsbs_pkg::REQ_LIST:
            state_nxt = (fill_r == '0) ? itsbs_pkg::S_OUT : itsbs_pkg::S_CMP;
          default: state_nxt = (!flag_r || $signed(lo_r) > $signed(hi_r)) ?
                               itsbs_pkg::S_OUT : itsbs_pkg::S_CMP;
        endcase
      end
      itsbs_pkg::S_CMP: begin
        case (req_r)
          itsbs_pkg::REQ_REMOVE: begin
            if (crsp.eq && (i_r + IW'(1) < fill_ext)) state_nxt = itsbs_pkg::S_SHIFT_RD;
            else if (crsp.eq || (i_r + IW'(1) >= fill_ext)) state_nxt = itsbs_pkg::S_OUT;
            else state_nxt = itsbs_pkg::S_RD;
          end
          itsbs_pkg::REQ_LIST: state_nxt = itsbs_pkg::S_OUT;
          default: state_nxt = crsp.eq ? itsbs_pkg::S_OUT : itsbs_pkg::S_RD;
        endcase
      end
      itsbs_pkg::S_SHIFT_RD: state_nxt = itsbs_pkg::S_SHIFT_WR;
      // The fill count already holds the reduced size while the gap is closed.
      itsbs_pkg::S_SHIFT_WR:
        state_nxt = (j_r + IW'(1) < fill_ext) ? itsbs_pkg::S_SHIFT_RD : itsbs_pkg::S_OUT;
      itsbs_pkg::S_SORT_LD:
        state_nxt = (i_r >= fill_ext) ? itsbs_pkg::S_OUT : itsbs_pkg::S_SORT_CMP;
      itsbs_pkg::S_SORT_CMP: state_nxt = itsbs_pkg::S_SORT_PUT;
      itsbs_pkg::S_SORT_PUT: begin
        // mrdata holds entry j, read issued in S_SORT_CMP.
        if (crsp.lt && j_r != '0) state_nxt = itsbs_pkg::S_SORT_CMP;
        else if (crsp.lt) state_nxt = itsbs_pkg::S_SORT_END;
        else state_nxt = itsbs_pkg::S_SORT_LD;
      end
      itsbs_pkg::S_SORT_END: state_nxt = itsbs_pkg::S_SORT_LD;
      itsbs_pkg::S_OUT: begin
        if (out_ready || !ov_r) begin
          if (req_r == itsbs_pkg::REQ_LIST && !olast_r && ov_r) state_nxt = itsbs_pkg::S_RD;
          else if (ov_r) state_nxt = itsbs_pkg::S_IDLE;
        end
      end
      default: state_nxt = itsbs_pkg::S_IDLE;
    endcase
  end

  // Memory controls.
  always_comb begin
    mwe    = 1'b0;
    mwaddr = i_r[AW-1:0];
    mwdata = key_r;
    mraddr = i_r[AW-1:0];
    case (state_r)
      itsbs_pkg::S_RD: begin
        if (req_r == itsbs_pkg::REQ_SEARCH) mraddr = mid[AW-1:0];
        if (req_r == itsbs_pkg::REQ_INSERT && fill_r < CW'(DEPTH)) begin
          mwe    = 1'b1;
          mwaddr = fill_r[AW-1:0];
        end
      end
      itsbs_pkg::S_SHIFT_RD: mraddr = AW'(j_r + IW'(1));
      itsbs_pkg::S_SHIFT_WR: begin
        mwe = 1'b1; mwaddr = j_r[AW-1:0]; mwdata = mrdata;
      end
      itsbs_pkg::S_SORT_LD: mraddr = i_r[AW-1:0];
      itsbs_pkg::S_SORT_CMP: mraddr = j_r[AW-1:0];
      itsbs_pkg::S_SORT_PUT: begin
        mwe = 1'b1;
        if (crsp.lt) begin
          mwaddr = AW'(j_r + IW'(1)); mwdata = mrdata;
        end else begin
          mwaddr = AW'(j_r + IW'(1)); mwdata = key_r;
        end
        mraddr = AW'(j_r - IW'(1));
      end
      itsbs_pkg::S_SORT_END: begin
        mwe = 1'b1; mwaddr = AW'(j_r + IW'(1)); mwdata = key_r;
      end
      default: ;
    endcase
  end

  // Registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= itsbs_pkg::S_IDLE;
      fill_r  <= '0;
      flag_r  <= 1'b0;
      ccnt_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ov_r && out_ready) ov_r <= 1'b0;
      case (state_r)
        itsbs_pkg::S_IDLE: begin
          if (accept) begin
            req_r  <= itsbs_pkg::req_t'(in_req_type);
            mode_r <= itsbs_pkg::sort_t'(in_sort_by);
            key_r  <= '{name: in_name_key & KMASK, kind: in_type_key & KMASK,
                        qty: in_quantity, pri: in_priority_req};
            i_r    <= (in_req_type == itsbs_pkg::REQ_SORT) ? IW'(1) : '0;
            lo_r   <= '0;
            hi_r   <= IW'(fill_r) - IW'(1);
            if (in_req_type == itsbs_pkg::REQ_SORT) ccnt_r <= '0;
            ost_r  <= itsbs_pkg::ST_OK;
            orec_r <= '0;
            opos_r <= '0;
            olast_r <= 1'b1;
          end
        end
        itsbs_pkg::S_RD: begin
          case (req_r)
            itsbs_pkg::REQ_INSERT: begin
              if (fill_r >= CW'(DEPTH)) ost_r <= itsbs_pkg::ST_FULL;
              else begin
                orec_r <= key_r; opos_r <= 4'(fill_r);
                fill_r <= fill_r + CW'(1); flag_r <= 1'b0;
              end
            end
            itsbs_pkg::REQ_REMOVE, itsbs_pkg::REQ_LIST:
              if (fill_r == '0) ost_r <= itsbs_pkg::ST_EMPTY;
            default: begin
              if (!flag_r) ost_r <= itsbs_pkg::ST_NOT_NAME;
              else if ($signed(lo_r) > $signed(hi_r)) ost_r <= itsbs_pkg::ST_NOT_FOUND;
              j_r <= mid;
            end
          endcase
        end
        itsbs_pkg::S_CMP: begin
          case (req_r)
            itsbs_pkg::REQ_REMOVE: begin
              if (crsp.eq) begin
                orec_r <= mrdata; opos_r <= 4'(i_r);
                j_r <= i_r;
                fill_r <= fill_r - CW'(1); flag_r <= 1'b0;
              end else if (i_r + IW'(1) >= fill_ext) ost_r <= itsbs_pkg::ST_NOT_FOUND;
              else i_r <= i_r + IW'(1);
            end
            itsbs_pkg::REQ_LIST: begin
              orec_r <= mrdata; opos_r <= 4'(i_r);
              olast_r <= (i_r + IW'(1) == fill_ext);
              i_r <= i_r + IW'(1);
            end
            default: begin
              if (crsp.eq) begin
                orec_r <= mrdata; opos_r <= 4'(j_r);
              end else if (crsp.lt) hi_r <= j_r - IW'(1);
              else lo_r <= j_r + IW'(1);
            end
          endcase
        end
        itsbs_pkg::S_SHIFT_WR: j_r <= j_r + IW'(1);
        itsbs_pkg::S_SORT_LD: begin
          if (i_r >= fill_ext) flag_r <= (mode_r == itsbs_pkg::SORT_NAME);
          j_r <= i_r - IW'(1);
        end
        itsbs_pkg::S_SORT_CMP: begin
          // Record i arrives on the first probe only; later probes keep the key.
          if (j_r + IW'(1) == i_r) key_r <= mrdata;
        end
        itsbs_pkg::S_SORT_PUT: begin
          if (ccnt_r != 8'hFF) ccnt_r <= ccnt_r + 8'd1;
          if (crsp.lt) j_r <= j_r - IW'(1);
          else i_r <= i_r + IW'(1);
        end
        itsbs_pkg::S_SORT_END: i_r <= i_r + IW'(1);
        itsbs_pkg::S_OUT: begin
          if (!ov_r && state_nxt == itsbs_pkg::S_OUT) ov_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Sort step: S_SORT_LD reads record i, S_SORT_CMP takes it as the key and reads entry j,
  // and S_SORT_PUT compares. A move copies entry j up one place and probes j-1; when the key
  // passes entry 0, S_SORT_END writes it at the front.

  assign out_valid          = ov_r;
  assign out_status         = ost_r;
  assign out_item_name      = orec_r.name;
  assign out_item_type      = orec_r.kind;
  assign out_item_quantity  = orec_r.qty;
  assign out_item_priority  = orec_r.pri;
  assign out_item_position  = opos_r;
  assign out_entry_count    = 5'(fill_r);
  assign out_compare_count  = ccnt_r;
  assign out_sorted_by_name = flag_r;
  assign out_last           = olast_r;

  // The table never holds more records than it has room for.
  assert property (@(posedge clk) disable iff (!rst_n) fill_r <= CW'(DEPTH))
    else $error("fill count overflow");
  // No new transaction is taken while a result waits.
  assert property (@(posedge clk) disable iff (!rst_n) ov_r |-> !in_ready)
    else $error("accepted while result pending");
  // A completed sort by any key other than name leaves the flag clear.
  assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && req_r == itsbs_pkg::REQ_SORT && mode_r != itsbs_pkg::SORT_NAME) |-> !flag_r)
    else $error("sorted flag wrong after sort");
endmodule
`default_nettype wire
